// ----- design/irc_message_field_tagger_macros.svh -----
// assertion macros for the irc message field tagger
// needs clk and rst_n in the scope of each use
`ifndef IRC_MESSAGE_FIELD_TAGGER_MACROS_SVH
`define IRC_MESSAGE_FIELD_TAGGER_MACROS_SVH

`ifndef SYNTHESIS
`define MFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFT_ASSERT_SAME(label, ante, cons, msg)
`define MFT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/mft_pkg.sv -----
// shared types, character codes and field kind codes of the irc message field tagger
// no dependencies
package mft_pkg;

  localparam int MAX_PARAMS = 15;
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 4;
  localparam int NSLOT      = 3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;

  localparam logic [KIND_W-1:0] KIND_NICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_USER   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HOST   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VERB   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MIDDLE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TRAIL  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd6;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_PREFIX = 6'b000010,
    PH_VERB   = 6'b000100,
    PH_MIDDLE = 6'b001000,
    PH_TRAIL  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    PART_NICK = 4'b0001,
    PART_USER = 4'b0010,
    PART_HOST = 4'b0100,
    PART_DROP = 4'b1000
  } part_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] field_kind;
    logic [IDX_W-1:0]  param_index;
    logic              token_start;
    logic              message_done;
  } result_t;

endpackage

// ----- design/mft_if.sv -----
// valid/ready channel interfaces for the message byte input and the tagged result output
// depends on mft_pkg
interface mft_in_if;
  import mft_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface mft_out_if;
  import mft_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] field_kind;
  logic [IDX_W-1:0]  param_index;
  logic              token_start;
  logic              message_done;

  modport source (
    output valid, output out_byte, output field_kind, output param_index,
    output token_start, output message_done, input ready
  );
  modport sink (
    input valid, input out_byte, input field_kind, input param_index,
    input token_start, input message_done, output ready
  );
endinterface

// ----- design/irc_message_field_tagger.sv -----
// irc message field tagger: tags each kept byte of a message line by field
// depends on mft_pkg, mft_if.sv and irc_message_field_tagger_macros.svh
// One message byte is taken per input beat and the tagger state is updated in the same
// cycle; its results (a released CR, the byte itself, the end result) land in a
// three-slot result register and leave one beat per cycle while the output is ready;
// the first result is in the cycle after the input beat. A byte that gives at most one
// result is accepted every cycle while the output is ready; a byte that gives two or
// three results holds the next byte back while the result register drains. Parameter
// indexes saturate at MAX_PARAMS.
`include "irc_message_field_tagger_macros.svh"

module irc_message_field_tagger (
  input logic  clk,
  input logic  rst_n,
  mft_in_if.sink    in_ch,
  mft_out_if.source out_ch
);
  import mft_pkg::*;

  phase_t           phase_r, phase_nxt;
  part_t            part_r, part_nxt;
  logic             in_tok_r, in_tok_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             held_cr_r, held_cr_nxt;
  logic             trail_st_r, trail_st_nxt;

  logic [NSLOT-1:0] pend_r, pend_nxt;
  result_t          slot_r [NSLOT];
  result_t          slot_nxt [NSLOT];
  logic [NSLOT-1:0] emit;

  logic             in_acc, out_acc, pend_single, is_ws, do_verb;
  logic [BYTE_W-1:0] b;
  logic [NSLOT-1:0] low_bit;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c < CNT_W'(MAX_PARAMS)) ? c + 1'b1 : c;
  endfunction

  function automatic logic [KIND_W-1:0] part_kind(input part_t p);
    unique case (p)
      PART_NICK: part_kind = KIND_NICK;
      PART_USER: part_kind = KIND_USER;
      default:   part_kind = KIND_HOST;
    endcase
  endfunction

  assign b           = in_ch.in_byte;
  assign is_ws       = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign pend_single = (pend_r == 3'b001) || (pend_r == 3'b010) || (pend_r == 3'b100);
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (pend_r == '0) || (out_ch.ready && pend_single);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign low_bit     = pend_r & (~pend_r + 1'b1);

  // per-byte parse step
  always_comb begin
    phase_nxt    = phase_r;
    part_nxt     = part_r;
    in_tok_nxt   = in_tok_r;
    cnt_nxt      = cnt_r;
    held_cr_nxt  = held_cr_r;
    trail_st_nxt = trail_st_r;
    emit         = '0;
    do_verb      = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_nxt[i] = '0;
    end

    unique case (phase_r)
      PH_START: begin
        if (b == CH_COLON) begin
          phase_nxt = PH_PREFIX;
        end else begin
          phase_nxt = PH_VERB;
          do_verb   = 1'b1;
        end
      end
      PH_PREFIX: begin
        priority if (b == CH_SPACE) begin
          phase_nxt  = PH_VERB;
          in_tok_nxt = 1'b0;
        end else if (part_r == PART_NICK && b == CH_BANG) begin
          part_nxt   = PART_USER;
          in_tok_nxt = 1'b0;
        end else if (part_r == PART_USER && b == CH_AT) begin
          part_nxt   = PART_HOST;
          in_tok_nxt = 1'b0;
        end else if (part_r == PART_HOST && b == CH_NUL) begin
          part_nxt = PART_DROP;
        end else if (part_r != PART_DROP) begin
          emit[1]     = 1'b1;
          slot_nxt[1] = '{b, part_kind(part_r), '0, ~in_tok_r, 1'b0};
          in_tok_nxt  = 1'b1;
        end else begin
          part_nxt = part_r;
        end
      end
      PH_VERB: do_verb = 1'b1;
      PH_MIDDLE: begin
        if (b == CH_COLON || is_ws) begin
          if (in_tok_r) begin
            cnt_nxt    = sat_inc(cnt_r);
            in_tok_nxt = 1'b0;
          end
          if (b == CH_COLON) begin
            phase_nxt = PH_TRAIL;
          end
        end else begin
          emit[1]     = 1'b1;
          slot_nxt[1] = '{b, KIND_MIDDLE, IDX_W'(cnt_r), ~in_tok_r, 1'b0};
          in_tok_nxt  = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (b == CH_LF) begin
          held_cr_nxt = 1'b0;
          if (trail_st_r) begin
            cnt_nxt = sat_inc(cnt_r);
          end
          trail_st_nxt = 1'b0;
          phase_nxt    = PH_DONE;
        end else begin
          if (held_cr_r) begin
            emit[0]      = 1'b1;
            slot_nxt[0]  = '{CH_CR, KIND_TRAIL, IDX_W'(cnt_r), ~trail_st_r, 1'b0};
            trail_st_nxt = 1'b1;
            held_cr_nxt  = 1'b0;
          end
          if (b == CH_CR) begin
            held_cr_nxt = 1'b1;
          end else begin
            emit[1]      = 1'b1;
            slot_nxt[1]  = '{b, KIND_TRAIL, IDX_W'(cnt_r),
                             ~(trail_st_r || held_cr_r), 1'b0};
            trail_st_nxt = 1'b1;
          end
        end
      end
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_START;
    endcase

    if (do_verb) begin
      if (b == CH_SPACE) begin
        phase_nxt  = PH_MIDDLE;
        in_tok_nxt = 1'b0;
      end else begin
        emit[1]     = 1'b1;
        slot_nxt[1] = '{b, KIND_VERB, '0, ~in_tok_r, 1'b0};
        in_tok_nxt  = 1'b1;
      end
    end

    if (in_ch.end_of_message) begin
      if (phase_nxt == PH_MIDDLE && in_tok_nxt) begin
        cnt_nxt = sat_inc(cnt_nxt);
      end
      if (phase_nxt == PH_TRAIL && trail_st_nxt) begin
        cnt_nxt = sat_inc(cnt_nxt);
      end
      emit[2]      = 1'b1;
      slot_nxt[2]  = '{'0, KIND_END, IDX_W'(cnt_nxt), 1'b0, 1'b1};
      phase_nxt    = PH_START;
      part_nxt     = PART_NICK;
      in_tok_nxt   = 1'b0;
      cnt_nxt      = '0;
      held_cr_nxt  = 1'b0;
      trail_st_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = emit;
    end else if (out_acc) begin
      pend_nxt = pend_r & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      part_r     <= PART_NICK;
      in_tok_r   <= 1'b0;
      cnt_r      <= '0;
      held_cr_r  <= 1'b0;
      trail_st_r <= 1'b0;
      pend_r     <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        part_r     <= part_nxt;
        in_tok_r   <= in_tok_nxt;
        cnt_r      <= cnt_nxt;
        held_cr_r  <= held_cr_nxt;
        trail_st_r <= trail_st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  // first pending slot goes out
  result_t head;
  always_comb begin
    priority if (pend_r[0]) begin
      head = slot_r[0];
    end else if (pend_r[1]) begin
      head = slot_r[1];
    end else begin
      head = slot_r[2];
    end
  end

  assign out_ch.valid        = |pend_r;
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.field_kind   = head.field_kind;
  assign out_ch.param_index  = head.param_index;
  assign out_ch.token_start  = head.token_start;
  assign out_ch.message_done = head.message_done;

  `MFT_ASSERT_NEXT(a_eom_clears, in_acc && in_ch.end_of_message, phase_r == PH_START && cnt_r == '0 && !held_cr_r, "state not cleared after end of message")
  `MFT_ASSERT_SAME(a_accept_drains, in_acc && pend_r != '0, out_acc && pend_single, "input beat taken while results still queued")
  `MFT_ASSERT_SAME(a_end_beat, out_ch.valid && out_ch.message_done, out_ch.field_kind == KIND_END && out_ch.out_byte == '0 && !out_ch.token_start, "malformed end beat")
  `MFT_ASSERT_NEXT(a_cr_held, in_acc && phase_r == PH_TRAIL && b == CH_CR && !in_ch.end_of_message, held_cr_r, "carriage return not held")

endmodule

// ----- test/mft_tag_checker.sv -----
// checker for the irc message field tagger: watches both channels, predicts the tagged
// result beats of every accepted message byte and compares them in order, field by field
// depends on mft_pkg and the channel interfaces of mft_if.sv
module mft_tag_checker (
  input  logic clk,
  input  logic rst_n,
  mft_in_if    in_ch,
  mft_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   tagged_seen
);
  import mft_pkg::*;

  phase_t            ph;
  part_t             part;
  logic              in_tok;
  logic              cr_held;
  logic              trail_on;
  logic [CNT_W-1:0]  n_params;
  result_t           expected_tags[$];
  int                mismatches = 0;
  int                waiting = 0;
  int                seen = 0;

  assign fail_count  = mismatches;
  assign pending     = waiting;
  assign tagged_seen = seen;

  function automatic void clear_tagger();
    ph       = PH_START;
    part     = PART_NICK;
    in_tok   = 1'b0;
    cr_held  = 1'b0;
    trail_on = 1'b0;
    n_params = '0;
  endfunction

  function automatic void expect_tag(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] kind,
                                     logic [IDX_W-1:0] idx, logic start, logic done);
    result_t r;
    r.out_byte     = b;
    r.field_kind   = kind;
    r.param_index  = idx;
    r.token_start  = start;
    r.message_done = done;
    expected_tags.insert(expected_tags.size(), r);
  endfunction

  function automatic void bump_params();
    if (n_params < MAX_PARAMS) n_params = n_params + 1'b1;
  endfunction

  function automatic void end_middle_token();
    if (in_tok) begin
      bump_params();
      in_tok = 1'b0;
    end
  endfunction

  function automatic void verb_tag(logic [BYTE_W-1:0] b);
    if (b == CH_SPACE) begin
      ph     = PH_MIDDLE;
      in_tok = 1'b0;
    end else begin
      expect_tag(b, KIND_VERB, '0, !in_tok, 1'b0);
      in_tok = 1'b1;
    end
  endfunction

  function automatic void trail_tag(logic [BYTE_W-1:0] b);
    expect_tag(b, KIND_TRAIL, IDX_W'(n_params), !trail_on, 1'b0);
    trail_on = 1'b1;
  endfunction

  function automatic void tag_byte(logic [BYTE_W-1:0] b, logic eom);
    logic [KIND_W-1:0] pkind;
    pkind = (part == PART_NICK) ? KIND_NICK : (part == PART_USER) ? KIND_USER : KIND_HOST;
    case (ph)
      PH_START: begin
        if (b == CH_COLON) begin
          ph = PH_PREFIX;
        end else begin
          ph = PH_VERB;
          verb_tag(b);
        end
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          ph     = PH_VERB;
          in_tok = 1'b0;
        end else if (part == PART_NICK && b == CH_BANG) begin
          part   = PART_USER;
          in_tok = 1'b0;
        end else if (part == PART_USER && b == CH_AT) begin
          part   = PART_HOST;
          in_tok = 1'b0;
        end else if (part == PART_HOST && b == CH_NUL) begin
          part = PART_DROP;
        end else if (part != PART_DROP) begin
          expect_tag(b, pkind, '0, !in_tok, 1'b0);
          in_tok = 1'b1;
        end
      end
      PH_VERB: verb_tag(b);
      PH_MIDDLE: begin
        if (b == CH_COLON) begin
          end_middle_token();
          ph = PH_TRAIL;
        end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
          end_middle_token();
        end else begin
          expect_tag(b, KIND_MIDDLE, IDX_W'(n_params), !in_tok, 1'b0);
          in_tok = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (b == CH_LF) begin
          cr_held = 1'b0;
          if (trail_on) bump_params();
          trail_on = 1'b0;
          ph       = PH_DONE;
        end else begin
          if (cr_held) begin
            trail_tag(CH_CR);
            cr_held = 1'b0;
          end
          if (b == CH_CR) cr_held = 1'b1;
          else trail_tag(b);
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (ph == PH_MIDDLE) end_middle_token();
      if (ph == PH_TRAIL && trail_on) bump_params();
      expect_tag('0, KIND_END, IDX_W'(n_params), 1'b0, 1'b1);
      clear_tagger();
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_tagger();
      expected_tags.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) tag_byte(in_ch.in_byte, in_ch.end_of_message);
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        if (expected_tags.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: byte %02h kind %0d idx %0d start %b done %b",
                     out_ch.out_byte, out_ch.field_kind, out_ch.param_index,
                     out_ch.token_start, out_ch.message_done);
        end else begin
          want = expected_tags.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.field_kind !== want.field_kind ||
              out_ch.param_index !== want.param_index ||
              out_ch.token_start !== want.token_start ||
              out_ch.message_done !== want.message_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at beat %0d: expected byte %02h kind %0d idx %0d start %b",
                        " done %b, got byte %02h kind %0d idx %0d start %b done %b"},
                       seen, want.out_byte, want.field_kind, want.param_index,
                       want.token_start, want.message_done, out_ch.out_byte,
                       out_ch.field_kind, out_ch.param_index, out_ch.token_start,
                       out_ch.message_done);
          end
        end
      end
    end
    waiting <= expected_tags.size();
  end

endmodule

// ----- test/tb_irc_message_field_tagger.sv -----
// testbench top for the irc message field tagger: drives message bytes and output stalls,
// directed lines first and then random lines, and gives the verdict from the checker
// depends on mft_pkg, mft_if.sv, mft_tag_checker.sv and the tagger itself
module tb_irc_message_field_tagger;
  import mft_pkg::*;

  localparam int STREAM_BYTES = 250;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              no_idle;
  int                cycles = 0;
  int                bytes_sent = 0;
  int                msgs_sent = 0;
  int                fail_count;
  int                pending;
  int                tagged_seen;
  logic [BYTE_W-1:0] msg[$];

  mft_in_if  in_ch();
  mft_out_if out_ch();

  irc_message_field_tagger u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mft_tag_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .tagged_seen (tagged_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 20);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] tok_char();
    if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(8'h80, 8'hFF));
    return BYTE_W'($urandom_range(8'h41, 8'h7A));
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] c);
    msg.insert(msg.size(), c);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic add_token(input int min_len);
    repeat ($urandom_range(min_len, 3)) add_byte(tok_char());
  endtask

  task automatic add_gap();
    int sel;
    repeat ($urandom_range(1, 2)) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: add_byte(CH_TAB);
        1: add_byte(BYTE_W'($urandom_range(CH_LF, CH_CR)));
        default: add_byte(CH_SPACE);
      endcase
    end
  endtask

  task automatic send_msg();
    foreach (msg[i]) begin
      if (!no_idle && $urandom_range(0, 99) < 20) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 2)) @(posedge clk);
      end
      in_ch.valid          <= 1'b1;
      in_ch.in_byte        <= msg[i];
      in_ch.end_of_message <= (i == msg.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      bytes_sent++;
    end
    msgs_sent++;
    msg.delete();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int          directed_bytes;
    int          nparams;
    logic [7:0]  b;
    bit          drained_mid;
    rst_n                = 1'b0;
    no_idle              = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = '0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    drained_mid          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full prefix with nul in host, middle, trailing with cr lf, bytes after lf
    add_text(":n!u@h");
    add_byte(CH_NUL);
    add_text("z V a:t");
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_text("q");
    send_msg();
    // colon as last byte
    add_text("P ");
    add_byte(CH_TAB);
    add_byte(CH_COLON);
    send_msg();
    // empty verb, trailing of a lone cr
    add_text(" :");
    add_byte(CH_CR);
    send_msg();
    // top byte value as verb, held cr released, final cr dropped
    add_byte(8'hFF);
    add_text(" :");
    add_byte(CH_CR);
    add_text("y");
    add_byte(CH_CR);
    send_msg();
    directed_bytes = bytes_sent;
    drain_results();

    while (bytes_sent < directed_bytes + STREAM_BYTES) begin
      no_idle <= (bytes_sent >= directed_bytes + 60) && (bytes_sent < directed_bytes + 150);
      if (!drained_mid && bytes_sent >= directed_bytes + STREAM_BYTES / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 10)) add_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 1)) begin
          add_byte(CH_COLON);
          add_token(0);
          if ($urandom_range(0, 3) != 0) begin
            add_byte(CH_BANG);
            add_token(0);
            if ($urandom_range(0, 3) != 0) begin
              add_byte(CH_AT);
              add_token(0);
              if ($urandom_range(0, 4) == 0) begin
                add_byte(CH_NUL);
                add_token(1);
              end
            end
          end
          add_byte(CH_SPACE);
        end
        add_token(1);
        nparams = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
        if (nparams > 0) add_byte(CH_SPACE);
        repeat (nparams) begin
          add_token(1);
          add_gap();
        end
        if ($urandom_range(0, 2) != 0) begin
          if (nparams == 0) add_byte(CH_SPACE);
          add_byte(CH_COLON);
          repeat ($urandom_range(0, 6)) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == CH_LF) b = CH_CR;
            add_byte(b);
          end
          case ($urandom_range(0, 3))
            0: ;
            1: add_byte(CH_CR);
            2: begin
              add_byte(CH_CR);
              add_byte(CH_LF);
            end
            default: begin
              add_byte(CH_LF);
              repeat ($urandom_range(0, 2)) add_byte(BYTE_W'($urandom_range(0, 255)));
            end
          endcase
        end
      end
      send_msg();
    end

    no_idle <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d message bytes in %0d lines (prefixes, saturated counts, noise),",
             bytes_sent, msgs_sent);
    $display("with %0d tagged result beats checked under stalls on both channels",
             tagged_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mft_pkg.sv
design/mft_if.sv
design/irc_message_field_tagger.sv
test/mft_tag_checker.sv
test/tb_irc_message_field_tagger.sv
